>>> hdl/comma_token_lexer_unit_assert.svh
// ---------------------------------------------------------------------------
// comma token lexer assertion macros
// shared check forms, clocked on i_clk and quiet while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef COMMA_TOKEN_LEXER_UNIT_ASSERT_SVH
`define COMMA_TOKEN_LEXER_UNIT_ASSERT_SVH

// condition holds whenever the antecedent holds, same edge
`define CTLA_HOLDS(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("comma token lexer check failed");

// condition holds on the edge after the antecedent
`define CTLA_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("comma token lexer check failed");

`endif

>>> hdl/ctlex_pkg.sv
// ---------------------------------------------------------------------------
// ctlex_pkg
// types, character codes and register map of the comma token lexer
// ---------------------------------------------------------------------------
package ctlex_pkg;

    // storage the original token buffer had; one slot holds the terminator
    localparam int TOKEN_BUFFER_SIZE = 1024;
    localparam int LEN_W             = 10;
    localparam logic [LEN_W-1:0] KEEP_CAP =
        (TOKEN_BUFFER_SIZE - 1 < 1023) ? LEN_W'(TOKEN_BUFFER_SIZE - 1) : LEN_W'(1023);

    // character codes
    localparam logic [7:0] CH_SEP_MAX = 8'd32;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_SLASH   = 8'h2f;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EAT_COMMA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SPLIT = 2'd2;

    localparam logic [LEN_W-1:0] RST_MAX_LEN    = 10'd1023;
    localparam logic             RST_EAT_COMMA  = 1'b1;
    localparam logic             RST_HIGH_SPLIT = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_HELD,
        MODE_QUOTE,
        MODE_AFTER_QUOTE,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR
    } t_mode;

    typedef struct packed {
        logic [LEN_W-1:0] max_len;
        logic             eat_comma;
        logic             high_split;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_token_end;
        logic             was_quoted;
        logic [LEN_W-1:0] token_length;
        logic             was_truncated;
        logic             last_of_run;
    } t_result;

    // up to two words produced by one text byte, r0 first
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result byte_item(logic [7:0] b, logic quoted);
        t_result r;
        r               = '0;
        r.out_byte      = b;
        r.was_quoted    = quoted;
        return r;
    endfunction

    function automatic t_result end_item(logic [LEN_W-1:0] len, logic trunc, logic quoted);
        t_result r;
        r               = '0;
        r.is_token_end  = 1'b1;
        r.was_quoted    = quoted;
        r.token_length  = len;
        r.was_truncated = trunc;
        return r;
    endfunction

endpackage

>>> hdl/ctlex_text_if.sv
// ---------------------------------------------------------------------------
// ctlex_text_if
// text byte channel into the lexer
// ---------------------------------------------------------------------------
interface ctlex_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

>>> hdl/ctlex_token_if.sv
// ---------------------------------------------------------------------------
// ctlex_token_if
// token word channel out of the lexer
// ---------------------------------------------------------------------------
interface ctlex_token_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_token_end;
    logic       was_quoted;
    logic [9:0] token_length;
    logic       was_truncated;
    logic       last_of_run;

    modport source (output valid, output out_byte, output is_token_end,
                    output was_quoted, output token_length, output was_truncated,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input is_token_end,
                    input was_quoted, input token_length, input was_truncated,
                    input last_of_run, output ready);
endinterface

>>> hdl/comma_token_lexer_unit.sv
// ---------------------------------------------------------------------------
// comma_token_lexer_unit
// text lexer: splits a byte stream into words and quoted strings, skips
// blanks and c style comments, streams token bytes plus an end word
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  i_text    in   valid / ready        text_byte (8)
//  o_token   out  valid / ready        out_byte, is_token_end, was_quoted,
//                                      token_length (10), was_truncated,
//                                      last_of_run
//  i_cfg_*   in   write enable only    i_cfg_idx (2), i_cfg_data (10)
//
//  one text byte is taken per cycle; its 0, 1 or 2 result words land in the
//  output queue on the same edge and leave it one per cycle while the sink
//  holds o_token.ready high; with the queue empty, the first result word of
//  a byte is visible the cycle after the byte is taken. i_text.ready drops
//  only while the four-entry output queue has fewer than two free slots, so
//  two-word bytes keep pace with the drain, the rest at one byte per cycle
//  reset is synchronous, active low; it clears the lexer to idle, empties
//  the queue and reloads the register defaults (1023, 1, 1)
//
module comma_token_lexer_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ctlex_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ctlex_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    ctlex_text_if.sink                            i_text,
    ctlex_token_if.source                         o_token
);
    import ctlex_pkg::*;

    t_cfg  r_cfg;
    t_push w_push;
    logic  w_room;
    logic  w_take;

    // register writes, indexes past the map are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len    <= RST_MAX_LEN;
            r_cfg.eat_comma  <= RST_EAT_COMMA;
            r_cfg.high_split <= RST_HIGH_SPLIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_LEN:    r_cfg.max_len    <= i_cfg_data[LEN_W-1:0];
                CFG_EAT_COMMA:  r_cfg.eat_comma  <= i_cfg_data[0];
                CFG_HIGH_SPLIT: r_cfg.high_split <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // accept whenever a worst-case pair of words still fits
    assign i_text.ready = w_room;
    assign w_take       = i_text.valid & w_room;

    // state machine: mode, kept length, drop flag, quote flag, parked byte
    ctlex_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_text.text_byte),
        .i_cfg   (r_cfg),
        .o_push  (w_push)
    );

    // result queue decouples the two handshakes
    ctlex_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_src   (o_token)
    );

endmodule

>>> hdl/ctlex_engine.sv
// ---------------------------------------------------------------------------
// ctlex_engine
// lexer state machine: one text byte in, up to two words out per cycle
// ---------------------------------------------------------------------------
module ctlex_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  ctlex_pkg::t_cfg i_cfg,
    output ctlex_pkg::t_push o_push
);
    import ctlex_pkg::*;

    `include "comma_token_lexer_unit_assert.svh"

    t_mode            r_mode,    n_mode;
    logic [LEN_W-1:0] r_kept,    n_kept;
    logic             r_dropped, n_dropped;
    logic             r_quoted,  n_quoted;
    logic [7:0]       r_held,    n_held;

    logic [LEN_W-1:0] w_lim;
    logic             w_lim_nz;
    logic             w_sep;
    logic             w_comma;
    logic             w_split;
    logic             w_in_comment;

    assign w_lim    = (i_cfg.max_len > KEEP_CAP) ? KEEP_CAP : i_cfg.max_len;
    assign w_lim_nz = (w_lim != '0);
    assign w_sep    = (i_byte <= CH_SEP_MAX);
    assign w_comma  = (i_byte == CH_COMMA);
    // high byte (if high_split) or uneaten comma ends the word, opens the next
    assign w_split  = (i_byte[7] & i_cfg.high_split) | (w_comma & ~i_cfg.eat_comma);
    assign w_in_comment = (r_mode == MODE_LINE) || (r_mode == MODE_BLOCK)
                          || (r_mode == MODE_BLOCK_STAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_kept    <= '0;
            r_dropped <= 1'b0;
            r_quoted  <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_kept    <= n_kept;
            r_dropped <= n_dropped;
            r_quoted  <= n_quoted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    always_comb begin
        t_result    v_res [2];
        logic [1:0] v_n;
        logic       v_word;

        n_mode    = r_mode;
        n_kept    = r_kept;
        n_dropped = r_dropped;
        n_quoted  = r_quoted;
        n_held    = r_held;
        v_res[0]  = '0;
        v_res[1]  = '0;
        v_n       = 2'd0;
        v_word    = 1'b0;

        if (i_take) begin
            unique case (r_mode)
                MODE_WORD: begin
                    v_word = 1'b1;
                end
                MODE_HELD: begin
                    if (r_held == CH_SLASH && i_byte == CH_SLASH) begin
                        n_mode = MODE_LINE;
                    end else if (r_held == CH_SLASH && i_byte == CH_STAR) begin
                        n_mode = MODE_BLOCK_STAR;
                    end else begin
                        n_mode = MODE_WORD;
                        if (n_kept < w_lim) begin
                            v_res[0] = byte_item(r_held, n_quoted);
                            v_n      = 2'd1;
                            n_kept   = n_kept + LEN_W'(1);
                        end else begin
                            n_dropped = 1'b1;
                        end
                        v_word = 1'b1;
                    end
                end
                MODE_QUOTE: begin
                    if (i_byte == CH_NUL) begin
                        v_res[0] = end_item(n_kept, n_dropped, n_quoted);
                        v_n      = 2'd1;
                        n_mode   = MODE_IDLE;
                    end else if (i_byte == CH_QUOTE) begin
                        v_res[0] = end_item(n_kept, n_dropped, n_quoted);
                        v_n      = 2'd1;
                        n_mode   = MODE_AFTER_QUOTE;
                    end else if (n_kept < w_lim) begin
                        v_res[0] = byte_item(i_byte, n_quoted);
                        v_n      = 2'd1;
                        n_kept   = n_kept + LEN_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (i_byte == CH_NUL || i_byte == CH_NEWLINE) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_BLOCK: begin
                    if (i_byte == CH_NUL) begin
                        n_mode = MODE_IDLE;
                    end else if (i_byte == CH_STAR) begin
                        n_mode = MODE_BLOCK_STAR;
                    end
                end
                MODE_BLOCK_STAR: begin
                    if (i_byte == CH_NUL || i_byte == CH_SLASH) begin
                        n_mode = MODE_IDLE;
                    end else if (i_byte != CH_STAR) begin
                        n_mode = MODE_BLOCK;
                    end
                end
                MODE_IDLE, MODE_AFTER_QUOTE: begin
                    if (r_mode == MODE_AFTER_QUOTE && w_comma && i_cfg.eat_comma) begin
                        n_mode = MODE_IDLE;
                    end else if (w_sep) begin
                        n_mode = MODE_IDLE;
                    end else if (i_byte == CH_QUOTE) begin
                        n_quoted  = 1'b1;
                        n_kept    = '0;
                        n_dropped = 1'b0;
                        n_mode    = MODE_QUOTE;
                    end else if (i_byte == CH_SLASH) begin
                        n_quoted  = 1'b0;
                        n_kept    = '0;
                        n_dropped = 1'b0;
                        n_held    = i_byte;
                        n_mode    = MODE_HELD;
                    end else begin
                        n_quoted  = 1'b0;
                        n_dropped = ~w_lim_nz;
                        n_kept    = w_lim_nz ? LEN_W'(1) : '0;
                        if (w_lim_nz) begin
                            v_res[0] = byte_item(i_byte, 1'b0);
                            v_n      = 2'd1;
                        end
                        n_mode = MODE_WORD;
                    end
                end
            endcase

            // word continuation, shared by an open word and a released held byte
            if (v_word) begin
                if (w_sep) begin
                    v_res[v_n[0]] = end_item(n_kept, n_dropped, n_quoted);
                    v_n           = v_n + 2'd1;
                    n_mode        = MODE_IDLE;
                end else if (w_split) begin
                    v_res[v_n[0]] = end_item(n_kept, n_dropped, n_quoted);
                    v_n           = v_n + 2'd1;
                    n_quoted      = 1'b0;
                    n_kept        = '0;
                    n_dropped     = 1'b0;
                    if (v_n != 2'd2) begin
                        if (w_lim_nz) begin
                            v_res[v_n[0]] = byte_item(i_byte, 1'b0);
                            v_n           = v_n + 2'd1;
                            n_kept        = LEN_W'(1);
                        end else begin
                            n_dropped = 1'b1;
                        end
                        n_mode = MODE_WORD;
                    end else begin
                        // out of room this cycle: park the byte
                        n_held = i_byte;
                        n_mode = MODE_HELD;
                    end
                end else if (w_comma) begin
                    v_res[v_n[0]] = end_item(n_kept, n_dropped, n_quoted);
                    v_n           = v_n + 2'd1;
                    n_mode        = MODE_IDLE;
                end else if (n_kept < w_lim) begin
                    v_res[v_n[0]] = byte_item(i_byte, n_quoted);
                    v_n           = v_n + 2'd1;
                    n_kept        = n_kept + LEN_W'(1);
                end else begin
                    n_dropped = 1'b1;
                end
            end
        end

        if (v_n == 2'd1) begin
            v_res[0].last_of_run = 1'b1;
        end else if (v_n == 2'd2) begin
            v_res[1].last_of_run = 1'b1;
        end

        o_push.count = v_n;
        o_push.r0    = v_res[0];
        o_push.r1    = v_res[1];
    end

    `CTLA_HOLDS(a_held_fresh, r_mode == MODE_HELD, r_kept == '0 && !r_dropped)
    `CTLA_HOLDS(a_quote_flag, r_mode == MODE_QUOTE || r_mode == MODE_AFTER_QUOTE, r_quoted)
    `CTLA_HOLDS(a_comment_silent, i_take && w_in_comment, o_push.count == 2'd0)

endmodule

>>> hdl/ctlex_outq.sv
// ---------------------------------------------------------------------------
// ctlex_outq
// four-entry result queue, takes up to two words a cycle, gives one on ready
// ---------------------------------------------------------------------------
module ctlex_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ctlex_pkg::t_push i_push,
    output logic             o_room,
    ctlex_token_if.source    o_src
);
    import ctlex_pkg::*;

    `include "comma_token_lexer_unit_assert.svh"

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_result          r_q [DEPTH];
    logic [PTR_W-1:0] r_wr,  n_wr;
    logic [PTR_W-1:0] r_rd,  n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             w_pop;
    t_result          w_head;

    assign w_head = r_q[r_rd];
    assign w_pop  = o_src.valid & o_src.ready;
    assign o_room = (r_cnt <= (PTR_W+1)'(DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.count);
        n_rd  = r_rd + PTR_W'(w_pop);
        n_cnt = r_cnt + (PTR_W+1)'(i_push.count) - (PTR_W+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_q[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_q[r_wr + PTR_W'(1)] <= i_push.r1;
        end
    end

    assign o_src.valid         = (r_cnt != '0);
    assign o_src.out_byte      = w_head.out_byte;
    assign o_src.is_token_end  = w_head.is_token_end;
    assign o_src.was_quoted    = w_head.was_quoted;
    assign o_src.token_length  = w_head.token_length;
    assign o_src.was_truncated = w_head.was_truncated;
    assign o_src.last_of_run   = w_head.last_of_run;

    `CTLA_HOLDS(a_no_overflow, 1'b1, r_cnt <= (PTR_W+1)'(DEPTH))
    `CTLA_HOLDS(a_pair_fits, i_push.count == 2'd2, r_cnt <= (PTR_W+1)'(DEPTH - 2))
    `CTLA_NEXT(a_partner_queued, w_pop && !w_head.last_of_run, o_src.valid)

endmodule
